// ===== design/sfp_pkg.sv =====
// Shared types, phase codes, register indexes and CRC helper for the sync frame parser.
package sfp_pkg;

  localparam int PHASE_W = 4;

  localparam logic [PHASE_W-1:0] PH_SYNC1   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_SYNC2   = 4'd1;
  localparam logic [PHASE_W-1:0] PH_TYPE    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SEQ     = 4'd3;
  localparam logic [PHASE_W-1:0] PH_LEN_LO  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_LEN_HI  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd6;
  localparam logic [PHASE_W-1:0] PH_CRC_LO  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_CRC_HI  = 4'd8;

  localparam logic [1:0] ST_GOOD      = 2'd0;
  localparam logic [1:0] ST_CRC_BAD   = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
  localparam logic [15:0] MAX_LEN_RST     = 16'd256;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int TDATA_W = 96;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_len;
  } sfp_cfg_t;

  typedef struct packed {
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic [15:0] payload_length;
    logic [7:0]  seq_number;
    logic [7:0]  frame_type;
    logic [1:0]  status;
    logic        is_end;
    logic [15:0] byte_index;
    logic [7:0]  payload_byte;
  } sfp_result_t;

  function automatic logic [15:0] sfp_crc_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/sfp_parser.sv =====
// Frame parser state machine: sync hunt, header capture, CRC accumulation and results.
module sfp_parser
  import sfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  sfp_cfg_t    cfg,
  output logic        res_valid,
  output sfp_result_t res
);

  logic [PHASE_W-1:0] phase, phase_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  held_type, held_type_next;
  logic [7:0]  held_seq, held_seq_next;
  logic [15:0] held_len, held_len_next;
  logic [15:0] count, count_next;
  logic [7:0]  crc_lo, crc_lo_next;

  logic [15:0] crc_upd;
  logic [15:0] count_inc;
  logic [15:0] len_full;
  logic [15:0] rcrc;
  logic        emit_end;
  logic [1:0]  st;
  logic [15:0] idx;
  logic [7:0]  pbyte;
  logic [15:0] rcrc_out;

  assign crc_upd   = sfp_crc_byte(crc, rx_byte);
  assign count_inc = count + 16'd1;
  assign len_full  = {rx_byte, held_len[7:0]};
  assign rcrc      = {rx_byte, crc_lo};

  always_comb begin
    phase_next     = phase;
    crc_next       = crc;
    held_type_next = held_type;
    held_seq_next  = held_seq;
    held_len_next  = held_len;
    count_next     = count;
    crc_lo_next    = crc_lo;
    res_valid      = 1'b0;
    emit_end       = 1'b0;
    st             = ST_GOOD;
    idx            = '0;
    pbyte          = '0;
    rcrc_out       = '0;
    unique case (phase)
      PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          held_type_next = '0;
          held_seq_next  = '0;
          held_len_next  = '0;
          count_next     = '0;
          crc_next       = CRC_INIT;
          phase_next     = PH_TYPE;
        end else if (rx_byte != cfg.sync_first) begin
          phase_next = PH_SYNC1;
        end
      end
      PH_TYPE: begin
        held_type_next = rx_byte;
        crc_next       = crc_upd;
        phase_next     = PH_SEQ;
      end
      PH_SEQ: begin
        held_seq_next = rx_byte;
        crc_next      = crc_upd;
        phase_next    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        held_len_next = {8'h00, rx_byte};
        crc_next      = crc_upd;
        phase_next    = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        held_len_next = len_full;
        crc_next      = crc_upd;
        count_next    = '0;
        if (len_full > cfg.max_len) begin
          phase_next = PH_SYNC1;
          res_valid  = 1'b1;
          emit_end   = 1'b1;
          st         = ST_TOO_LARGE;
        end else if (len_full == 16'd0) begin
          phase_next = PH_CRC_LO;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_next   = crc_upd;
        res_valid  = 1'b1;
        pbyte      = rx_byte;
        idx        = count;
        count_next = count_inc;
        if (count_inc >= held_len) begin
          phase_next = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_next = rx_byte;
        phase_next  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        phase_next = PH_SYNC1;
        res_valid  = 1'b1;
        emit_end   = 1'b1;
        idx        = count;
        rcrc_out   = rcrc;
        st         = (rcrc == crc) ? ST_GOOD : ST_CRC_BAD;
      end
      default: begin
        phase_next = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  always_comb begin
    res.payload_byte   = pbyte;
    res.byte_index     = idx;
    res.is_end         = emit_end;
    res.status         = st;
    res.frame_type     = held_type_next;
    res.seq_number     = held_seq_next;
    res.payload_length = held_len_next;
    res.received_crc   = rcrc_out;
    res.computed_crc   = crc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SYNC1;
      crc       <= CRC_INIT;
      held_type <= '0;
      held_seq  <= '0;
      held_len  <= '0;
      count     <= '0;
      crc_lo    <= '0;
    end else if (step) begin
      phase     <= phase_next;
      crc       <= crc_next;
      held_type <= held_type_next;
      held_seq  <= held_seq_next;
      held_len  <= held_len_next;
      count     <= count_next;
      crc_lo    <= crc_lo_next;
    end
  end

endmodule

// ===== design/sync_frame_parser_crc16_top.sv =====
// Top level of the sync frame parser: stream ports, configuration registers, result register.
//
// Usage:
//   s_axis carries one received byte per word (tdata[7:0]). m_axis carries
//   results: tuser = 1 marks an end-of-frame word with status, tuser = 0 a
//   payload byte. A word is taken when tvalid and tready are both high.
//   Each result is registered before it reaches m_axis; one input word is
//   accepted every cycle, limited only by the result register: s_axis_tready
//   is high whenever the result register is empty or is being drained in the
//   same cycle. Only payload bytes, the high CRC byte (end word) and the high
//   length byte of an oversized frame (end word) give a result. When the
//   receiver holds m_axis_tready low with a result waiting, input stalls until it is taken.
//   The cfg channel writes sync_first (index 0), sync_second (1) and
//   max_payload_len (2); index 3 is ignored. cfg_ready is always high.
//   Write it only while the block is idle.
//   Reset (rst, synchronous) returns the parser to sync hunt, empties the
//   result register and restores 0xAA, 0x55 and 256 to the registers.
module sync_frame_parser_crc16_top
  import sfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // rx_byte[7:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // payload_byte[7:0], byte_index[23:8], status[25:24], frame_type[33:26],
  // seq_number[41:34], payload_length[57:42], received_crc[73:58],
  // computed_crc[89:74], zero[95:90]
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tuser,   // is_end[0]
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  sfp_cfg_t    cfg;
  logic        step;
  logic        res_valid;
  sfp_result_t res;
  logic        out_valid;
  sfp_result_t out_res;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= SYNC_FIRST_RST;
      cfg.sync_second <= SYNC_SECOND_RST;
      cfg.max_len     <= MAX_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  cfg.sync_first  <= cfg_data[7:0];
        CFG_SYNC_SECOND: cfg.sync_second <= cfg_data[7:0];
        CFG_MAX_LEN:     cfg.max_len     <= cfg_data;
        default: ;
      endcase
    end
  end

  sfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (s_axis_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.is_end;
  assign m_axis_tdata  = {6'b0, out_res.computed_crc, out_res.received_crc,
                          out_res.payload_length, out_res.seq_number,
                          out_res.frame_type, out_res.status,
                          out_res.byte_index, out_res.payload_byte};

`ifndef SYNTHESIS
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.is_end) |->
      (out_res.status == ST_GOOD && out_res.received_crc == 16'd0))
    else $error("payload word carries end status or CRC");

  a_good_matches: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.is_end && out_res.status == ST_GOOD) |->
      (out_res.received_crc == out_res.computed_crc))
    else $error("good status with CRC mismatch");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.status <= ST_TOO_LARGE))
    else $error("undefined status code");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result is stalled");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result register not empty after reset");
`endif

endmodule

// ===== dv/frame_checker.sv =====
// Watches the sync frame parser's channels, predicts each result word and compares it.
module frame_checker
  import sfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [TDATA_W-1:0] m_axis_tdata,
  input  logic               m_axis_tuser,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  pbyte;
    logic [15:0] index;
    logic        last;
    logic [1:0]  status;
    logic [7:0]  ftype;
    logic [7:0]  seq;
    logic [15:0] length;
    logic [15:0] rx_crc;
    logic [15:0] calc_crc;
  } frame_word_t;

  frame_word_t        want_q[$];

  logic [7:0]         sync_a;
  logic [7:0]         sync_b;
  logic [15:0]        len_limit;

  logic [PHASE_W-1:0] phase;
  logic [15:0]        crc_acc;
  logic [7:0]         f_type;
  logic [7:0]         f_seq;
  logic [15:0]        f_len;
  logic [15:0]        f_count;
  logic [7:0]         crc_lo;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [15:0] crc16_ccitt(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ 16'h1021;
      end
    end
    return c;
  endfunction

  task automatic queue_word(input logic [7:0] pbyte, input logic [15:0] index,
                            input logic last, input logic [1:0] status,
                            input logic [15:0] rx_crc);
    frame_word_t w;
    w.pbyte    = pbyte;
    w.index    = index;
    w.last     = last;
    w.status   = status;
    w.ftype    = f_type;
    w.seq      = f_seq;
    w.length   = f_len;
    w.rx_crc   = rx_crc;
    w.calc_crc = crc_acc;
    want_q.push_back(w);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] rx;
    case (phase)
      PH_SYNC2: begin
        if (b == sync_b) begin
          f_type  = '0;
          f_seq   = '0;
          f_len   = '0;
          f_count = '0;
          crc_acc = 16'hFFFF;
          phase   = PH_TYPE;
        end else if (b != sync_a) begin
          phase = PH_SYNC1;
        end
      end
      PH_TYPE: begin
        f_type  = b;
        crc_acc = crc16_ccitt(crc_acc, b);
        phase   = PH_SEQ;
      end
      PH_SEQ: begin
        f_seq   = b;
        crc_acc = crc16_ccitt(crc_acc, b);
        phase   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        f_len   = {8'h00, b};
        crc_acc = crc16_ccitt(crc_acc, b);
        phase   = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        f_len   = {b, f_len[7:0]};
        crc_acc = crc16_ccitt(crc_acc, b);
        f_count = '0;
        if (f_len > len_limit) begin
          phase = PH_SYNC1;
          queue_word(8'h00, 16'h0000, 1'b1, ST_TOO_LARGE, 16'h0000);
        end else begin
          phase = (f_len == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_acc = crc16_ccitt(crc_acc, b);
        queue_word(b, f_count, 1'b0, ST_GOOD, 16'h0000);
        f_count = f_count + 16'd1;
        if (f_count >= f_len) begin
          phase = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo = b;
        phase  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        rx    = {b, crc_lo};
        phase = PH_SYNC1;
        queue_word(8'h00, f_count, 1'b1, (rx == crc_acc) ? ST_GOOD : ST_CRC_BAD, rx);
      end
      default: begin
        phase = (b == sync_a) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  endtask

  task automatic cmp(input string field, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      errors = errors + 1;
    end
  endtask

  always @(posedge clk) begin
    frame_word_t want;
    if (rst) begin
      want_q.delete();
      sync_a    = SYNC_FIRST_RST;
      sync_b    = SYNC_SECOND_RST;
      len_limit = MAX_LEN_RST;
      phase     = PH_SYNC1;
      crc_acc   = 16'hFFFF;
      f_type    = '0;
      f_seq     = '0;
      f_len     = '0;
      f_count   = '0;
      crc_lo    = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYNC_FIRST:  sync_a    = cfg_data[7:0];
          CFG_SYNC_SECOND: sync_b    = cfg_data[7:0];
          CFG_MAX_LEN:     len_limit = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
          errors = errors + 1;
        end else begin
          want = want_q.pop_front();
          cmp("payload_byte", 16'(want.pbyte), 16'(m_axis_tdata[7:0]));
          cmp("byte_index", want.index, m_axis_tdata[23:8]);
          cmp("is_end", 16'(want.last), 16'(m_axis_tuser));
          cmp("status", 16'(want.status), 16'(m_axis_tdata[25:24]));
          cmp("frame_type", 16'(want.ftype), 16'(m_axis_tdata[33:26]));
          cmp("seq_number", 16'(want.seq), 16'(m_axis_tdata[41:34]));
          cmp("payload_length", want.length, m_axis_tdata[57:42]);
          cmp("received_crc", want.rx_crc, m_axis_tdata[73:58]);
          cmp("computed_crc", want.calc_crc, m_axis_tdata[89:74]);
          cmp("tdata padding", 16'h0000, 16'(m_axis_tdata[TDATA_W-1:90]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata);
      end
    end
    pending = want_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// Stimulus, stall control, watchdog and verdict for the sync frame parser.
module tb;
  import sfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         LONG_HOLD  = 400;
  localparam int         QUIET_MAX  = 3000;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = 8'h00;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index     = 2'd0;
  logic [15:0]        cfg_data      = 16'h0000;

  int                 errors;
  int                 pending;

  int                 gap_pct   = 0;
  int                 stall_pct = 0;
  int                 hold_reqs = 0;
  int                 sent      = 0;
  int                 quiet     = 0;

  logic [7:0]         cur_sync1 = SYNC_FIRST_RST;
  logic [7:0]         cur_sync2 = SYNC_SECOND_RST;
  logic [15:0]        cur_max   = MAX_LEN_RST;

  sync_frame_parser_crc16_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  frame_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending)
  );

  always #5 clk = ~clk;

  // hold off for a long stretch on request, otherwise stall at random
  initial begin
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_reqs) begin
        served = hold_reqs;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_MAX);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SYNC_FIRST:  cur_sync1 = val[7:0];
      CFG_SYNC_SECOND: cur_sync2 = val[7:0];
      CFG_MAX_LEN:     cur_max   = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drive_frame(input logic [7:0] ftype, input logic [7:0] seq,
                             input logic [15:0] len, input bit bad_crc, input bit rep_sync);
    logic [15:0] crc;
    logic [7:0]  hdr [4];
    crc    = CRC_INIT;
    hdr[0] = ftype;
    hdr[1] = seq;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    send(cur_sync1);
    if (rep_sync && cur_sync1 != cur_sync2) begin
      send(cur_sync1);
    end
    send(cur_sync2);
    for (int i = 0; i < 4; i++) begin
      crc = sfp_crc_byte(crc, hdr[i]);
      send(hdr[i]);
    end
    if (len > cur_max) begin
      return;
    end
    for (int i = 0; i < int'(len); i++) begin
      hdr[0] = 8'($urandom);
      crc    = sfp_crc_byte(crc, hdr[0]);
      send(hdr[0]);
    end
    if (bad_crc) begin
      crc = crc ^ (16'h0001 << $urandom_range(15));
    end
    send(crc[7:0]);
    send(crc[15:8]);
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 8 && cur_max != 16'hFFFF) begin
      return 16'($urandom_range(65535, int'(cur_max) + 1));
    end
    if (r < 9 && cur_max <= 16'd256) begin
      return cur_max;
    end
    return 16'($urandom_range((cur_max < 16'd8) ? int'(cur_max) : 8));
  endfunction

  task automatic run_phase(input int n, input bit with_hold);
    int stop;
    int mid;
    int r;
    bit hold_due;
    stop     = sent + n;
    mid      = sent + n / 2;
    hold_due = with_hold;
    while (sent < stop) begin
      if (hold_due && sent >= mid) begin
        hold_reqs++;
        hold_due = 1'b0;
      end
      r = $urandom_range(99);
      if (r < 80) begin
        drive_frame(8'($urandom), 8'($urandom), pick_len(), $urandom_range(9) == 0,
                    $urandom_range(7) == 0);
      end else if (r < 90) begin
        repeat ($urandom_range(4, 1)) send(8'($urandom));
      end else begin
        send(cur_sync1);
        send(cur_sync2);
        repeat ($urandom_range(3)) send(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send(cur_sync1);
    send(8'h12);
    drive_frame(8'h00, 8'hFF, 16'd0, 1'b0, 1'b1);
    drive_frame(8'hFF, 8'h00, 16'd2, 1'b1, 1'b0);
    drive_frame(8'h7E, 8'h81, 16'd257, 1'b0, 1'b0);
    drive_frame(8'h81, 8'h7E, 16'hFFFF, 1'b0, 1'b0);
    run_phase(250, 1'b1);
    settle();

    write_reg(CFG_SYNC_FIRST, 16'hFF00);
    write_reg(CFG_SYNC_SECOND, 16'h00FF);
    write_reg(CFG_MAX_LEN, 16'h0000);
    gap_pct = 84;
    run_phase(250, 1'b0);
    settle();

    write_reg(CFG_SYNC_FIRST, 16'h00FF);
    write_reg(CFG_SYNC_SECOND, 16'h5A00);
    write_reg(CFG_MAX_LEN, 16'hFFFF);
    gap_pct   = 0;
    stall_pct = 84;
    run_phase(300, 1'b0);
    settle();

    // equal sync bytes: the second-sync match takes priority
    write_reg(CFG_SYNC_FIRST, 16'h005A);
    write_reg(CFG_SYNC_SECOND, 16'h005A);
    write_reg(CFG_MAX_LEN, 16'd16);
    gap_pct   = 32;
    stall_pct = 32;
    run_phase(250, 1'b0);
    settle();

    write_reg(CFG_SYNC_FIRST, 16'h00AA);
    write_reg(CFG_SYNC_SECOND, 16'h0055);
    write_reg(CFG_MAX_LEN, 16'd3);
    write_reg(CFG_UNUSED, 16'hFFFF);
    gap_pct   = 0;
    stall_pct = 0;
    run_phase(250, 1'b0);
    settle();

    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
